@@ hw/rtl/tle_pkg.sv @@
// tle_pkg: byte codes, result kinds and escape parser modes for the line editor
// no dependencies; imported by terminal_line_editor_core
`default_nettype none

package tle_pkg;

    localparam int CNT_W = 7;   // cursor and tail counts, 0..64

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_mode;

    localparam t_kind KIND_STATUS = 2'd0;
    localparam t_kind KIND_BYTE   = 2'd1;
    localparam t_kind KIND_EMPTY  = 2'd2;
    localparam t_kind KIND_REJECT = 2'd3;

    localparam t_mode M_IDLE  = 3'd0;
    localparam t_mode M_ESC   = 3'd1;
    localparam t_mode M_FIRST = 3'd2;
    localparam t_mode M_VAL1  = 3'd3;
    localparam t_mode M_VAL2  = 3'd4;

    localparam logic [7:0] B_ETX   = 8'h03;
    localparam logic [7:0] B_EOT   = 8'h04;
    localparam logic [7:0] B_BS    = 8'h08;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_CAN   = 8'h18;
    localparam logic [7:0] B_SUB   = 8'h1A;
    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_GS    = 8'h1D;
    localparam logic [7:0] B_RS    = 8'h1E;
    localparam logic [7:0] B_DEL   = 8'h7F;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_TILDE = 8'h7E;
    localparam logic [7:0] B_LBRK  = 8'h5B;
    localparam logic [7:0] B_SEMI  = 8'h3B;
    localparam logic [7:0] B_ZERO  = 8'h30;
    localparam logic [7:0] B_NINE  = 8'h39;
    localparam logic [7:0] B_CMD_C = 8'h43;
    localparam logic [7:0] B_CMD_D = 8'h44;

    localparam logic [15:0] SAT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

@@ hw/rtl/tle_ram.sv @@
// tle_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/terminal_line_editor_core.sv @@
// terminal_line_editor_core: line editor top level, decode sequencer and output register
// depends on tle_pkg and tle_ram
//
// usage
//   input channel: one terminal byte per beat (i_in_byte, i_chunk_last),
//   i_in_valid / o_in_stall. output channel: result beats o_kind, o_out_byte,
//   o_last, o_cursor, o_tail, o_echo_on with o_out_valid / i_out_stall.
//   each input beat gives one status, empty-line or reject beat, or a run of
//   cursor+tail line bytes on a flush; o_last marks the final beat of an input.
// line store walk
//   the line store is one ram, walked by a single index counter one entry at
//   a time (read, then write or output load). an insert shifts each tail byte
//   up one entry from the end, a delete shifts each tail byte down one entry,
//   and a flush reads each line byte into the output register in order.
//   o_in_stall is high from acceptance until the last result is loaded, so a
//   new input beat is taken only once the last one is through.
// reset
//   synchronous active-low i_rst_n clears cursor, tail, parser state and drop
//   flag, sets echo on and empties the output register. the line store is not
//   cleared; only entries below cursor+tail are ever read.
// stall
//   a result waits in the output register while i_out_stall is high; the
//   sequencer holds until the register frees up, nothing is lost.
`default_nettype none

module terminal_line_editor_core
    import tle_pkg::*;
#(
    parameter int LINE_LEN = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_chunk_last,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic [6:0]  o_cursor,
    output logic [6:0]  o_tail,
    output logic        o_echo_on
);

    localparam int AW = $clog2(LINE_LEN);
    localparam logic [CNT_W-1:0] LEN_C = CNT_W'(LINE_LEN);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_WR = 4'd3;
    localparam logic [3:0] S_DEL_RD = 4'd4;
    localparam logic [3:0] S_DEL_WR = 4'd5;
    localparam logic [3:0] S_FL_GO  = 4'd6;
    localparam logic [3:0] S_FL_RD  = 4'd7;
    localparam logic [3:0] S_FL_LD  = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [7:0]       r_byte, n_byte;
    logic             r_endc, n_endc;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_tail, n_tail;
    logic [15:0]      r_seq, n_seq;
    t_mode            r_mode, n_mode;
    logic             r_echo, n_echo;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_flush, n_flush;
    t_kind            r_ekind, n_ekind;

    // output register
    logic             r_ovalid, n_ovalid;
    t_kind            r_okind, n_okind;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_olast, n_olast;
    logic [CNT_W-1:0] r_ocursor, n_ocursor;
    logic [CNT_W-1:0] r_otail, n_otail;
    logic             r_oecho, n_oecho;

    // ram port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic             out_free;
    logic [CNT_W-1:0] line_len;
    logic             is_digit;
    logic [15:0]      digit_val;
    logic [19:0]      acc_wide;
    logic [15:0]      acc_sat;
    logic [15:0]      run_val;
    logic             do_run;

    assign out_free  = !r_ovalid || !i_out_stall;
    assign line_len  = r_cursor + r_tail;
    assign is_digit  = (r_byte >= B_ZERO) && (r_byte <= B_NINE);
    assign digit_val = {8'd0, r_byte - B_ZERO};
    // v*10 + digit as shifts and adds, saturated
    assign acc_wide  = {1'b0, r_seq, 3'd0} + {3'd0, r_seq, 1'b0} + {4'd0, digit_val};
    assign acc_sat   = (acc_wide > {4'd0, SAT_MAX}) ? SAT_MAX : acc_wide[15:0];

    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_endc    = r_endc;
        n_cursor  = r_cursor;
        n_tail    = r_tail;
        n_seq     = r_seq;
        n_mode    = r_mode;
        n_echo    = r_echo;
        n_drop    = r_drop;
        n_idx     = r_idx;
        n_len     = r_len;
        n_flush   = r_flush;
        n_ekind   = r_ekind;
        n_ovalid  = r_ovalid && i_out_stall;
        n_okind   = r_okind;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_ocursor = r_ocursor;
        n_otail   = r_otail;
        n_oecho   = r_oecho;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];
        run_val   = r_seq;
        do_run    = 1'b0;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in_byte;
                    n_endc  = i_chunk_last;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_flush = 1'b0;
                n_ekind = KIND_STATUS;
                n_state = S_EMIT;
                if (r_drop) begin
                    if (r_endc) begin
                        n_drop = 1'b0;
                    end
                end else if (r_tail >= LEN_C) begin
                    n_ekind = KIND_REJECT;
                    if (!r_endc) begin
                        n_drop = 1'b1;
                    end
                end else if (r_mode != M_IDLE) begin
                    // escape sequence parser
                    case (r_mode)
                        M_ESC: begin
                            n_mode = (r_byte == B_LBRK) ? M_FIRST : M_IDLE;
                        end
                        M_FIRST: begin
                            if (is_digit) begin
                                n_seq  = digit_val;
                                n_mode = M_VAL1;
                            end else begin
                                n_seq   = 16'd1;
                                run_val = 16'd1;
                                do_run  = 1'b1;
                                n_mode  = M_IDLE;
                            end
                        end
                        M_VAL1: begin
                            if (is_digit) begin
                                n_seq = acc_sat;
                            end else if (r_byte == B_SEMI) begin
                                n_mode = M_VAL2;
                            end else begin
                                do_run = 1'b1;
                                n_mode = M_IDLE;
                            end
                        end
                        M_VAL2: begin
                            // second value is parsed but has no effect
                            if (!is_digit) begin
                                do_run = 1'b1;
                                n_mode = M_IDLE;
                            end
                        end
                        default: begin
                            n_mode = M_IDLE;
                        end
                    endcase
                    if (do_run) begin
                        if (r_byte == B_CMD_D && run_val <= {9'd0, r_cursor}) begin
                            n_tail   = r_tail + run_val[CNT_W-1:0];
                            n_cursor = r_cursor - run_val[CNT_W-1:0];
                        end else if (r_byte == B_CMD_C && run_val <= {9'd0, r_tail}) begin
                            n_tail   = r_tail - run_val[CNT_W-1:0];
                            n_cursor = r_cursor + run_val[CNT_W-1:0];
                        end
                    end
                end else if (r_byte == B_DEL || r_byte == B_BS) begin
                    if (r_cursor != '0) begin
                        n_cursor = r_cursor - 1'b1;
                        n_idx    = r_cursor - 1'b1;
                        n_state  = S_DEL_RD;
                    end
                end else if (r_byte == B_ESC) begin
                    n_mode = M_ESC;
                end else if (r_byte == B_CR || r_byte == B_LF) begin
                    n_state = S_FL_GO;
                end else if (r_byte == B_GS) begin
                    n_echo = 1'b0;
                end else if (r_byte == B_RS) begin
                    n_echo = 1'b1;
                end else if (r_byte == B_TAB) begin
                    n_state = S_EMIT;
                end else begin
                    // printable and all other bytes insert; some also flush
                    n_flush = (r_byte == B_ETX) || (r_byte == B_EOT) ||
                              (r_byte == B_CAN) || (r_byte == B_SUB);
                    if (line_len < LEN_C) begin
                        n_idx   = line_len;
                        n_state = S_INS_RD;
                    end else if (n_flush) begin
                        n_state = S_FL_GO;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx > r_cursor) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx - 1'b1);
                    n_state   = S_INS_WR;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cursor[AW-1:0];
                    ram_wdata = r_byte;
                    n_cursor  = r_cursor + 1'b1;
                    n_state   = r_flush ? S_FL_GO : S_EMIT;
                end
            end
            S_INS_WR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx - 1'b1;
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (r_idx < line_len) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + 1'b1);
                    n_state   = S_DEL_WR;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DEL_WR: begin
                ram_we  = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = S_DEL_RD;
            end
            S_FL_GO: begin
                n_len    = line_len;
                n_cursor = '0;
                n_tail   = '0;
                n_idx    = '0;
                if (line_len == '0) begin
                    n_ekind = KIND_EMPTY;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_FL_RD: begin
                ram_re  = 1'b1;
                n_state = S_FL_LD;
            end
            S_FL_LD: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = KIND_BYTE;
                    n_obyte   = ram_rdata;
                    n_olast   = (r_idx == r_len - 1'b1);
                    n_ocursor = r_cursor;
                    n_otail   = r_tail;
                    n_oecho   = r_echo;
                    n_idx     = r_idx + 1'b1;
                    n_state   = (r_idx == r_len - 1'b1) ? S_IDLE : S_FL_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_okind   = r_ekind;
                    n_obyte   = 8'd0;
                    n_olast   = 1'b1;
                    n_ocursor = r_cursor;
                    n_otail   = r_tail;
                    n_oecho   = r_echo;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_tail   <= '0;
            r_seq    <= '0;
            r_mode   <= M_IDLE;
            r_echo   <= 1'b1;
            r_drop   <= 1'b0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_tail   <= n_tail;
            r_seq    <= n_seq;
            r_mode   <= n_mode;
            r_echo   <= n_echo;
            r_drop   <= n_drop;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_endc    <= n_endc;
        r_idx     <= n_idx;
        r_len     <= n_len;
        r_ekind   <= n_ekind;
        r_okind   <= n_okind;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
        r_ocursor <= n_ocursor;
        r_otail   <= n_otail;
        r_oecho   <= n_oecho;
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_out_byte  = r_obyte;
    assign o_last      = r_olast;
    assign o_cursor    = r_ocursor;
    assign o_tail      = r_otail;
    assign o_echo_on   = r_oecho;

endmodule

`default_nettype wire

@@ tb/terminal_line_editor_core_chk.sv @@
// terminal_line_editor_core_chk: watches both channels, predicts result beats and compares them
// depends on tle_pkg for result kinds, parser modes and byte codes
`default_nettype none

module terminal_line_editor_core_chk
    import tle_pkg::*;
#(
    parameter int LINE_LEN = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_chunk_last,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [7:0]  i_out_byte,
    input  wire         i_last,
    input  wire  [6:0]  i_cursor,
    input  wire  [6:0]  i_tail,
    input  wire         i_echo_on,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] cur;
        logic [6:0] tl;
        logic       echo;
    } t_beat;

    t_beat      beat_q[$];
    logic [7:0] line_mem [LINE_LEN];
    int         cur_cnt;
    int         tail_cnt;
    int         arg_one;
    int         arg_two;
    t_mode      mode;
    logic       echo;
    logic       dropping;

    initial begin
        o_errors = 0;
        for (int i = 0; i < LINE_LEN; i++) line_mem[i] = 8'h00;
    end

    assign o_pending = beat_q.size();

    function automatic int sat_acc(int v, logic [7:0] b);
        int r;
        r = v * 10 + int'(b - B_ZERO);
        return (r > int'(SAT_MAX)) ? int'(SAT_MAX) : r;
    endfunction

    function automatic logic is_dig(logic [7:0] b);
        return (b >= B_ZERO) && (b <= B_NINE);
    endfunction

    task automatic put_beat(t_kind k, logic [7:0] d, logic lst);
        t_beat e;
        e.kind = k;
        e.data = d;
        e.last = lst;
        e.cur  = cur_cnt[6:0];
        e.tl   = tail_cnt[6:0];
        e.echo = echo;
        beat_q.push_back(e);
    endtask

    task automatic ins_char(logic [7:0] b);
        if (cur_cnt + tail_cnt < LINE_LEN) begin
            for (int i = cur_cnt + tail_cnt; i > cur_cnt; i--) line_mem[i] = line_mem[i-1];
            line_mem[cur_cnt] = b;
            cur_cnt++;
        end
    endtask

    task automatic del_char();
        if (cur_cnt != 0) begin
            cur_cnt--;
            for (int i = cur_cnt; i < cur_cnt + tail_cnt && i + 1 < LINE_LEN; i++)
                line_mem[i] = line_mem[i+1];
        end
    endtask

    task automatic move_cursor(logic [7:0] b);
        if (b == B_CMD_D && arg_one <= cur_cnt) begin
            tail_cnt += arg_one;
            cur_cnt  -= arg_one;
        end else if (b == B_CMD_C && arg_one <= tail_cnt) begin
            tail_cnt -= arg_one;
            cur_cnt  += arg_one;
        end
    endtask

    task automatic parse_seq(logic [7:0] b);
        case (mode)
            M_ESC: mode = (b == B_LBRK) ? M_FIRST : M_IDLE;
            M_FIRST: begin
                if (is_dig(b)) begin
                    arg_one = int'(b - B_ZERO);
                    arg_two = 0;
                    mode = M_VAL1;
                end else begin
                    arg_one = 1;
                    move_cursor(b);
                    mode = M_IDLE;
                end
            end
            M_VAL1: begin
                if (is_dig(b)) arg_one = sat_acc(arg_one, b);
                else if (b == B_SEMI) mode = M_VAL2;
                else begin
                    move_cursor(b);
                    mode = M_IDLE;
                end
            end
            M_VAL2: begin
                if (is_dig(b)) arg_two = sat_acc(arg_two, b);
                else begin
                    move_cursor(b);
                    mode = M_IDLE;
                end
            end
            default: mode = M_IDLE;
        endcase
    endtask

    // work out every result beat caused by one input beat
    task automatic edit_line(logic [7:0] b, logic endc);
        logic flush;
        logic reject;
        int   len;
        flush  = 1'b0;
        reject = 1'b0;
        if (dropping) begin
            if (endc) dropping = 1'b0;
        end else if (tail_cnt >= LINE_LEN) begin
            reject = 1'b1;
            if (!endc) dropping = 1'b1;
        end else if (mode != M_IDLE) begin
            parse_seq(b);
        end else if (b >= B_SPACE && b <= B_TILDE) begin
            ins_char(b);
        end else begin
            case (b)
                B_DEL, B_BS:  del_char();
                B_ESC:        mode = M_ESC;
                B_CR, B_LF:   flush = 1'b1;
                B_GS:         echo = 1'b0;
                B_RS:         echo = 1'b1;
                B_TAB:        ;
                B_ETX, B_EOT, B_CAN, B_SUB: begin
                    ins_char(b);
                    flush = 1'b1;
                end
                default:      ins_char(b);
            endcase
        end
        if (reject) begin
            put_beat(KIND_REJECT, 8'h00, 1'b1);
        end else if (flush) begin
            len = cur_cnt + tail_cnt;
            if (len > LINE_LEN) len = LINE_LEN;
            cur_cnt  = 0;
            tail_cnt = 0;
            if (len == 0) put_beat(KIND_EMPTY, 8'h00, 1'b1);
            for (int i = 0; i < len; i++) put_beat(KIND_BYTE, line_mem[i], i == len - 1);
        end else begin
            put_beat(KIND_STATUS, 8'h00, 1'b1);
        end
    endtask

    task automatic report(string fld, int exp_v, int got_v);
        if (o_errors < 10)
            $display("mismatch %s: expected %0d got %0d", fld, exp_v, got_v);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_beat e;
        if (!i_rst_n) begin
            beat_q.delete();
            cur_cnt  = 0;
            tail_cnt = 0;
            arg_one  = 0;
            arg_two  = 0;
            mode     = M_IDLE;
            echo     = 1'b1;
            dropping = 1'b0;
        end else begin
            if (i_in_valid && !i_in_stall) edit_line(i_in_byte, i_chunk_last);
            if (i_out_valid && !i_out_stall) begin
                if (beat_q.size() == 0) begin
                    report("unexpected beat kind", -1, i_kind);
                end else begin
                    e = beat_q.pop_front();
                    if (i_kind != e.kind)       report("kind", e.kind, i_kind);
                    if (i_out_byte != e.data)   report("out_byte", e.data, i_out_byte);
                    if (i_last != e.last)       report("last", e.last, i_last);
                    if (i_cursor != e.cur)      report("cursor", e.cur, i_cursor);
                    if (i_tail != e.tl)         report("tail", e.tl, i_tail);
                    if (i_echo_on != e.echo)    report("echo_on", e.echo, i_echo_on);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/terminal_line_editor_core_tb.sv @@
// terminal_line_editor_core_tb: stimulus and verdict for the terminal line editor
// depends on tle_pkg, terminal_line_editor_core and terminal_line_editor_core_chk
`default_nettype none

module terminal_line_editor_core_tb;
    import tle_pkg::*;

    localparam int LINE_LEN    = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_RAND      = 100;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_chunk_last = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic [6:0] o_cursor;
    logic [6:0] o_tail;
    logic       o_echo_on;
    int         err_cnt;
    int         wait_cnt;
    int         cycle_cnt = 0;
    int         idle_pct = 0;     // sender gap chance per cycle
    int         stall_pct = 0;    // receiver stall chance per cycle
    int         items = 0;

    always #6 i_clk = ~i_clk;

    terminal_line_editor_core #(.LINE_LEN(LINE_LEN)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in_byte(i_in_byte), .i_chunk_last(i_chunk_last),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_out_byte(o_out_byte), .o_last(o_last),
        .o_cursor(o_cursor), .o_tail(o_tail), .o_echo_on(o_echo_on)
    );

    terminal_line_editor_core_chk #(.LINE_LEN(LINE_LEN)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_in_byte(i_in_byte), .i_chunk_last(i_chunk_last),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_kind(o_kind), .i_out_byte(o_out_byte), .i_last(o_last),
        .i_cursor(o_cursor), .i_tail(o_tail), .i_echo_on(o_echo_on),
        .o_errors(err_cnt), .o_pending(wait_cnt)
    );

    // receiver side: random stall, one decision per edge
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input beat; valid stays high into the next beat unless a gap is rolled
    task automatic key(logic [7:0] b, logic endc = 1'b1);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_chunk_last <= endc;
        do @(posedge i_clk); while (o_in_stall);
        items++;
    endtask

    // ESC [ digits final, optional second value
    task automatic csi(int n_dig, logic [7:0] fin, int n_two = -1);
        key(B_ESC);
        key(B_LBRK);
        repeat (n_dig) key(B_ZERO + 8'($urandom_range(9)));
        if (n_two >= 0) begin
            key(B_SEMI);
            repeat (n_two) key(B_ZERO + 8'($urandom_range(9)));
        end
        key(fin);
    endtask

    // fill the line, put the cursor at the start so the tail is full, then probe;
    // a full tail rejects every later byte, so this runs last
    task automatic full_tail(logic endc);
        key(B_CR);
        repeat (LINE_LEN) key(B_SPACE + 8'($urandom_range(94)));
        key(B_ESC); key(B_LBRK); key("6"); key("4"); key(B_CMD_D);
        key(8'($urandom), endc);
        repeat ($urandom_range(3)) key(8'($urandom), 1'b0);
        key(8'($urandom), 1'b1);
    endtask

    initial begin
        int r;
        int base;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and every control byte the editor handles
        key(B_SPACE); key(B_TILDE); key(8'h00); key(8'hFF, 1'b0);
        key(B_TAB); key(B_BS); key(B_DEL); key(B_GS); key(B_RS);
        key(B_CR); key(B_LF);                       // second flush sends an empty line
        key(B_ESC); key("x"); key("a");             // escape not followed by '['
        key(B_ESC); key(B_LBRK); key(B_CMD_D);      // no digits acts as one
        key(B_ESC); key(B_LBRK); key("9"); key("9"); key(B_CMD_C);  // too far, ignored
        key(B_ESC); key(B_LBRK); key("1"); key(B_SEMI); key("5"); key(B_CMD_C);
        key(B_ESC); key(B_LBRK); key("1"); key(B_SEMI); key(B_SEMI);  // second ';' ends it
        key(B_ESC); key(B_LBRK); key("2"); key("Z");  // unknown final byte
        csi(7, B_CMD_D);                            // saturating value
        key("q"); key(B_ETX); key("w"); key(B_EOT); key(B_CAN); key(B_SUB);
        repeat (LINE_LEN + 1) key(B_SPACE + 8'($urandom_range(94)));  // no room at the end
        key(B_ETX);                                 // no room, still flushes

        // random part in four pressure phases
        base = items;
        while (items - base < N_RAND) begin
            case (((items - base) * 4) / N_RAND)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            r = $urandom_range(99);
            if (r < 40)      key(B_SPACE + 8'($urandom_range(94)), 1'($urandom));
            else if (r < 50) key(8'($urandom), 1'($urandom));
            else if (r < 63) begin
                case ($urandom_range(3))
                    0: csi($urandom_range(3), B_CMD_C);
                    1: csi($urandom_range(3), B_CMD_D);
                    2: csi($urandom_range(2), ($urandom_range(1) ? B_CMD_C : B_CMD_D),
                           $urandom_range(6));
                    default: csi($urandom_range(6), 8'($urandom));
                endcase
            end
            else if (r < 71) key($urandom_range(1) ? B_BS : B_DEL);
            else if (r < 78) begin
                case ($urandom_range(5))
                    0: key(B_CR);  1: key(B_LF);  2: key(B_ETX);
                    3: key(B_EOT); 4: key(B_CAN); default: key(B_SUB);
                endcase
            end
            else if (r < 86) begin
                case ($urandom_range(2))
                    0: key(B_GS); 1: key(B_RS); default: key(B_TAB);
                endcase
            end
            else if (r < 90) key(B_ESC, 1'($urandom));
            else             key(B_ZERO + 8'($urandom_range(11)), 1'($urandom));
        end

        // full tail: reject, drop to chunk end, then reject again
        full_tail(1'b0);
        key(B_CR);
        key(B_LF, 1'b0);
        key(B_LF);
        i_in_valid <= 1'b0;
        idle_pct = 0;

        while (wait_cnt != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0 && wait_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ terminal_line_editor_core.f @@
hw/rtl/tle_pkg.sv
hw/rtl/tle_ram.sv
hw/rtl/terminal_line_editor_core.sv
tb/terminal_line_editor_core_chk.sv
tb/terminal_line_editor_core_tb.sv
